@@ src/closest_points_between_3d_lines_defines.svh @@
// Assertion macros for the closest points block.
`ifndef CLOSEST_POINTS_BETWEEN_3D_LINES_DEFINES_SVH
`define CLOSEST_POINTS_BETWEEN_3D_LINES_DEFINES_SVH

// Same-cycle implication.
`define CPL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/cpl_pkg.sv @@
// Shared constants and types for the closest points block.
package cpl_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int CFG_WIDTH       = 32;
    localparam int CFG_IDX_W       = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_LEN = 2'd0,
        REG_MIN_DEN = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_B_DEGEN  = 2'd1,
        ST_A_DEGEN  = 2'd2,
        ST_PARALLEL = 2'd3
    } status_t;

endpackage

@@ src/cpl_if.sv @@
// Item channel interfaces for the closest points block.
interface cpl_in_if import cpl_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] line_a_start_x;
    logic signed [COORD_WIDTH-1:0] line_a_start_y;
    logic signed [COORD_WIDTH-1:0] line_a_start_z;
    logic signed [COORD_WIDTH-1:0] line_a_end_x;
    logic signed [COORD_WIDTH-1:0] line_a_end_y;
    logic signed [COORD_WIDTH-1:0] line_a_end_z;
    logic signed [COORD_WIDTH-1:0] line_b_start_x;
    logic signed [COORD_WIDTH-1:0] line_b_start_y;
    logic signed [COORD_WIDTH-1:0] line_b_start_z;
    logic signed [COORD_WIDTH-1:0] line_b_end_x;
    logic signed [COORD_WIDTH-1:0] line_b_end_y;
    logic signed [COORD_WIDTH-1:0] line_b_end_z;

    modport source (
        output valid, line_a_start_x, line_a_start_y, line_a_start_z,
               line_a_end_x, line_a_end_y, line_a_end_z,
               line_b_start_x, line_b_start_y, line_b_start_z,
               line_b_end_x, line_b_end_y, line_b_end_z,
        input  ready
    );
    modport sink (
        input  valid, line_a_start_x, line_a_start_y, line_a_start_z,
               line_a_end_x, line_a_end_y, line_a_end_z,
               line_b_start_x, line_b_start_y, line_b_start_z,
               line_b_end_x, line_b_end_y, line_b_end_z,
        output ready
    );
endinterface

interface cpl_out_if import cpl_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic signed [COORD_WIDTH-1:0] point_a_x;
    logic signed [COORD_WIDTH-1:0] point_a_y;
    logic signed [COORD_WIDTH-1:0] point_a_z;
    logic signed [COORD_WIDTH-1:0] point_b_x;
    logic signed [COORD_WIDTH-1:0] point_b_y;
    logic signed [COORD_WIDTH-1:0] point_b_z;

    modport source (
        output valid, status, point_a_x, point_a_y, point_a_z,
               point_b_x, point_b_y, point_b_z,
        input  ready
    );
    modport sink (
        input  valid, status, point_a_x, point_a_y, point_a_z,
               point_b_x, point_b_y, point_b_z,
        output ready
    );
endinterface

@@ src/cpl_div_lane.sv @@
// Pipelined rounding divider with offset add and saturation, one bit per stage.
module cpl_div_lane import cpl_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int NW          = 2 * (4 * COORD_WIDTH_DEF + 9) + COORD_WIDTH_DEF + 2,
    parameter int DENW        = 2 * (2 * COORD_WIDTH_DEF + 4),
    parameter int QB          = COORD_WIDTH_DEF + 4
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [NW-1:0]          num,
    input  logic        [DENW-1:0]        den,
    input  logic signed [COORD_WIDTH-1:0] base,
    output logic signed [COORD_WIDTH-1:0] point
);

    localparam int WW   = ((NW > DENW + QB) ? NW : DENW + QB) + 1;
    localparam int SUMW = QB + 3;
    localparam logic signed [SUMW-1:0] S_MAX = SUMW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SUMW-1:0] S_MIN = -S_MAX - SUMW'(1);

    logic        [NW-1:0]          nmag_reg;
    logic                          neg_reg;
    logic        [DENW-1:0]        d_reg;
    logic signed [COORD_WIDTH-1:0] base_reg;

    logic        [WW-1:0]          r_reg    [QB+1];
    logic        [QB-1:0]          q_reg    [QB+1];
    logic                          neg_p    [QB+1];
    logic                          ovf_p    [QB+1];
    logic        [DENW-1:0]        d_p      [QB+1];
    logic signed [COORD_WIDTH-1:0] base_p   [QB+1];
    logic signed [COORD_WIDTH-1:0] point_reg;

    logic        [NW-1:0]          nmag_next;
    logic        [WW-1:0]          nz;
    logic        [WW-1:0]          dz_b;
    logic        [WW-1:0]          dz_c;
    logic        [QB:0]            qm;
    logic signed [SUMW-1:0]        sum;
    logic signed [COORD_WIDTH-1:0] point_next;

    assign nmag_next = num[NW-1] ? (~num + NW'(1)) : num;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nmag_reg <= nmag_next;
            neg_reg  <= num[NW-1];
            d_reg    <= den;
            base_reg <= base;
        end
    end

    assign nz   = {{(WW-NW){1'b0}}, nmag_reg};
    assign dz_b = {{(WW-DENW){1'b0}}, d_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]  <= nz;
            q_reg[0]  <= '0;
            neg_p[0]  <= neg_reg;
            ovf_p[0]  <= nz >= (dz_b << QB);
            d_p[0]    <= d_reg;
            base_p[0] <= base_reg;
        end
    end

    for (genvar i = 0; i < QB; i++)
    begin : g_step
        logic [WW-1:0] dk;
        assign dk = {{(WW-DENW){1'b0}}, d_p[i]} << (QB - 1 - i);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (r_reg[i] >= dk)
                begin
                    r_reg[i+1] <= r_reg[i] - dk;
                    q_reg[i+1] <= q_reg[i] | (QB'(1) << (QB - 1 - i));
                end
                else
                begin
                    r_reg[i+1] <= r_reg[i];
                    q_reg[i+1] <= q_reg[i];
                end
                neg_p[i+1]  <= neg_p[i];
                ovf_p[i+1]  <= ovf_p[i];
                d_p[i+1]    <= d_p[i];
                base_p[i+1] <= base_p[i];
            end
        end
    end

    // round half away from zero on the magnitude
    assign dz_c = {{(WW-DENW){1'b0}}, d_p[QB]};
    assign qm   = {1'b0, q_reg[QB]} + (QB+1)'((r_reg[QB] << 1) >= dz_c);
    assign sum  = SUMW'(base_p[QB]) +
                  (neg_p[QB] ? -$signed({2'b00, qm}) : $signed({2'b00, qm}));

    always_comb
    begin
        if (ovf_p[QB])
            point_next = neg_p[QB] ? COORD_WIDTH'(S_MIN) : COORD_WIDTH'(S_MAX);
        else if (sum > S_MAX)
            point_next = COORD_WIDTH'(S_MAX);
        else if (sum < S_MIN)
            point_next = COORD_WIDTH'(S_MIN);
        else
            point_next = sum[COORD_WIDTH-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            point_reg <= point_next;
    end

    assign point = point_reg;

endmodule

@@ src/closest_points_between_3d_lines.sv @@
// Top level: closest points between two 3D lines, fully pipelined.
// Pipeline depth is set by the
// split wide multipliers and the one-quotient-bit-per-stage dividers.
// Throughput: one item per cycle; a stalled output holds the whole pipeline.
// Reset clears valid bits and sets both thresholds to 1; datapath registers
// are not reset.
module closest_points_between_3d_lines import cpl_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    cpl_in_if.sink               in_ch,
    cpl_out_if.source            out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_data
);

    localparam int DW       = COORD_WIDTH + 1;
    localparam int PW       = 2 * DW;
    localparam int SW       = PW + 2;
    localparam int HW       = SW / 2;
    localparam int BW       = 2 * SW + 1;
    localparam int DENW     = 2 * SW;
    localparam int NW       = BW + DW;
    localparam int PC       = COORD_WIDTH + 2;
    localparam int PPW      = 2 * PC;
    localparam int QB       = COORD_WIDTH + 4;
    localparam int LANE_LAT = QB + 3;
    localparam int PRE      = 8;

    logic [CFG_WIDTH-1:0] min_len_reg;
    logic [CFG_WIDTH-1:0] min_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= CFG_WIDTH'(1);
            min_den_reg <= CFG_WIDTH'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_LEN: min_len_reg <= cfg_data;
                REG_MIN_DEN: min_den_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic en;
    logic v_reg  [PRE];
    logic lv_reg [LANE_LAT];

    assign en          = !lv_reg[LANE_LAT-1] || out_ch.ready;
    assign in_ch.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PRE; i++)
                v_reg[i] <= 1'b0;
            for (int i = 0; i < LANE_LAT; i++)
                lv_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_ch.valid;
            for (int i = 1; i < PRE; i++)
                v_reg[i] <= v_reg[i-1];
            lv_reg[0] <= v_reg[PRE-1];
            for (int i = 1; i < LANE_LAT; i++)
                lv_reg[i] <= lv_reg[i-1];
        end
    end

    // S1: differences
    logic signed [COORD_WIDTH-1:0] a0_in [3];
    logic signed [COORD_WIDTH-1:0] a1_in [3];
    logic signed [COORD_WIDTH-1:0] b0_in [3];
    logic signed [COORD_WIDTH-1:0] b1_in [3];

    assign a0_in[0] = in_ch.line_a_start_x;
    assign a0_in[1] = in_ch.line_a_start_y;
    assign a0_in[2] = in_ch.line_a_start_z;
    assign a1_in[0] = in_ch.line_a_end_x;
    assign a1_in[1] = in_ch.line_a_end_y;
    assign a1_in[2] = in_ch.line_a_end_z;
    assign b0_in[0] = in_ch.line_b_start_x;
    assign b0_in[1] = in_ch.line_b_start_y;
    assign b0_in[2] = in_ch.line_b_start_z;
    assign b1_in[0] = in_ch.line_b_end_x;
    assign b1_in[1] = in_ch.line_b_end_y;
    assign b1_in[2] = in_ch.line_b_end_z;

    logic signed [COORD_WIDTH-1:0] a0_reg [PRE][3];
    logic signed [COORD_WIDTH-1:0] b0_reg [PRE][3];
    logic signed [DW-1:0]          da_reg [6][3];
    logic signed [DW-1:0]          db_reg [6][3];
    logic signed [DW-1:0]          w_reg  [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a0_reg[0][i] <= a0_in[i];
                b0_reg[0][i] <= b0_in[i];
                da_reg[0][i] <= DW'(a1_in[i]) - DW'(a0_in[i]);
                db_reg[0][i] <= DW'(b1_in[i]) - DW'(b0_in[i]);
                w_reg[i]     <= DW'(a0_in[i]) - DW'(b0_in[i]);
            end
            for (int s = 1; s < PRE; s++)
                for (int i = 0; i < 3; i++)
                begin
                    a0_reg[s][i] <= a0_reg[s-1][i];
                    b0_reg[s][i] <= b0_reg[s-1][i];
                end
            for (int s = 1; s < 6; s++)
                for (int i = 0; i < 3; i++)
                begin
                    da_reg[s][i] <= da_reg[s-1][i];
                    db_reg[s][i] <= db_reg[s-1][i];
                end
        end
    end

    // S2: element products
    logic signed [PW-1:0] paa_reg [3];
    logic signed [PW-1:0] pbb_reg [3];
    logic signed [PW-1:0] pab_reg [3];
    logic signed [PW-1:0] pwa_reg [3];
    logic signed [PW-1:0] pwb_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                paa_reg[i] <= PW'(da_reg[0][i]) * PW'(da_reg[0][i]);
                pbb_reg[i] <= PW'(db_reg[0][i]) * PW'(db_reg[0][i]);
                pab_reg[i] <= PW'(da_reg[0][i]) * PW'(db_reg[0][i]);
                pwa_reg[i] <= PW'(w_reg[i]) * PW'(da_reg[0][i]);
                pwb_reg[i] <= PW'(w_reg[i]) * PW'(db_reg[0][i]);
            end
        end
    end

    // S3: dot products
    logic signed [SW-1:0] daa_reg, dbb_reg, dab_reg, wda_reg, wdb_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            daa_reg <= SW'(paa_reg[0]) + SW'(paa_reg[1]) + SW'(paa_reg[2]);
            dbb_reg <= SW'(pbb_reg[0]) + SW'(pbb_reg[1]) + SW'(pbb_reg[2]);
            dab_reg <= SW'(pab_reg[0]) + SW'(pab_reg[1]) + SW'(pab_reg[2]);
            wda_reg <= SW'(pwa_reg[0]) + SW'(pwa_reg[1]) + SW'(pwa_reg[2]);
            wdb_reg <= SW'(pwb_reg[0]) + SW'(pwb_reg[1]) + SW'(pwb_reg[2]);
        end
    end

    // S4: half-width partial products of the dot cross terms, length checks
    logic signed [SW-1:0]    mx [6];
    logic signed [SW-1:0]    my [6];
    logic signed [HW-1:0]    xh [6];
    logic signed [HW-1:0]    yh [6];
    logic        [HW-1:0]    xl [6];
    logic        [HW-1:0]    yl [6];
    logic signed [2*HW-1:0]  pp_hh_reg [6];
    logic signed [2*HW-1:0]  pp_hl_reg [6];
    logic signed [2*HW-1:0]  pp_lh_reg [6];
    logic        [2*HW-1:0]  pp_ll_reg [6];
    logic signed [SW-1:0]    min_len_ext;
    status_t                 len_st_reg [3];
    status_t                 len_st_next;

    assign mx[0] = daa_reg;
    assign my[0] = dbb_reg;
    assign mx[1] = dab_reg;
    assign my[1] = dab_reg;
    assign mx[2] = wdb_reg;
    assign my[2] = dab_reg;
    assign mx[3] = wda_reg;
    assign my[3] = dbb_reg;
    assign mx[4] = wdb_reg;
    assign my[4] = daa_reg;
    assign mx[5] = wda_reg;
    assign my[5] = dab_reg;

    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            xh[k] = mx[k][SW-1:HW];
            yh[k] = my[k][SW-1:HW];
            xl[k] = mx[k][HW-1:0];
            yl[k] = my[k][HW-1:0];
        end
    end

    assign min_len_ext = $signed({{(SW-CFG_WIDTH){1'b0}}, min_len_reg});

    always_comb
    begin
        if (dbb_reg < min_len_ext)
            len_st_next = ST_B_DEGEN;
        else if (daa_reg < min_len_ext)
            len_st_next = ST_A_DEGEN;
        else
            len_st_next = ST_OK;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 6; k++)
            begin
                pp_hh_reg[k] <= (2*HW)'(xh[k]) * (2*HW)'(yh[k]);
                pp_hl_reg[k] <= (2*HW)'(xh[k]) * $signed((2*HW)'(yl[k]));
                pp_lh_reg[k] <= $signed((2*HW)'(xl[k])) * (2*HW)'(yh[k]);
                pp_ll_reg[k] <= (2*HW)'(xl[k]) * (2*HW)'(yl[k]);
            end
            len_st_reg[0] <= len_st_next;
            len_st_reg[1] <= len_st_reg[0];
            len_st_reg[2] <= len_st_reg[1];
        end
    end

    // S5: cross products of dots
    logic signed [DENW-1:0] m_reg [6];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 6; k++)
                m_reg[k] <= (DENW'(pp_hh_reg[k]) <<< (2 * HW))
                          + ((DENW'(pp_hl_reg[k]) + DENW'(pp_lh_reg[k])) <<< HW)
                          + $signed(DENW'(pp_ll_reg[k]));
        end
    end

    // S6: denominator and numerators
    logic signed [BW-1:0] den_reg, numa_reg, numb_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg  <= BW'(m_reg[0]) - BW'(m_reg[1]);
            numa_reg <= BW'(m_reg[2]) - BW'(m_reg[3]);
            numb_reg <= BW'(m_reg[4]) - BW'(m_reg[5]);
        end
    end

    // S7: sliced numerator products, final status. den is |da x db|^2, never negative.
    logic signed [PPW-1:0]  qa_reg [3][4];
    logic signed [PPW-1:0]  qb_reg [3][4];
    logic        [DENW-1:0] dmag6_reg;
    logic signed [BW-1:0]   min_den_ext;
    status_t                st_next;
    status_t                st6_reg;

    assign min_den_ext = $signed({{(BW-CFG_WIDTH){1'b0}}, min_den_reg});

    always_comb
    begin
        if (len_st_reg[2] != ST_OK)
            st_next = len_st_reg[2];
        else if (den_reg == '0 || den_reg < min_den_ext)
            st_next = ST_PARALLEL;
        else
            st_next = ST_OK;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    qa_reg[i][j] <= $signed(PPW'(numa_reg[j*PC +: PC])) * PPW'(da_reg[5][i]);
                    qb_reg[i][j] <= $signed(PPW'(numb_reg[j*PC +: PC])) * PPW'(db_reg[5][i]);
                end
                qa_reg[i][3] <= PPW'($signed(numa_reg[BW-1:3*PC])) * PPW'(da_reg[5][i]);
                qb_reg[i][3] <= PPW'($signed(numb_reg[BW-1:3*PC])) * PPW'(db_reg[5][i]);
            end
            dmag6_reg <= den_reg[DENW-1:0];
            st6_reg   <= st_next;
        end
    end

    // S8: scaled numerators
    logic signed [NW-1:0]   pa_reg [3];
    logic signed [NW-1:0]   pb_reg [3];
    logic        [DENW-1:0] dmag_reg;
    status_t                st7_reg;
    status_t                lst_reg [LANE_LAT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pa_reg[i] <= (NW'(qa_reg[i][0]) + (NW'(qa_reg[i][1]) <<< PC))
                           + ((NW'(qa_reg[i][2]) <<< (2 * PC))
                              + (NW'(qa_reg[i][3]) <<< (3 * PC)));
                pb_reg[i] <= (NW'(qb_reg[i][0]) + (NW'(qb_reg[i][1]) <<< PC))
                           + ((NW'(qb_reg[i][2]) <<< (2 * PC))
                              + (NW'(qb_reg[i][3]) <<< (3 * PC)));
            end
            dmag_reg   <= dmag6_reg;
            st7_reg    <= st6_reg;
            lst_reg[0] <= st7_reg;
            for (int i = 1; i < LANE_LAT; i++)
                lst_reg[i] <= lst_reg[i-1];
        end
    end

    logic signed [COORD_WIDTH-1:0] pt_a [3];
    logic signed [COORD_WIDTH-1:0] pt_b [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        cpl_div_lane #(
            .COORD_WIDTH (COORD_WIDTH),
            .NW          (NW),
            .DENW        (DENW),
            .QB          (QB)
        ) u_lane_a (
            .clk   (clk),
            .en    (en),
            .num   (pa_reg[i]),
            .den   (dmag_reg),
            .base  (a0_reg[PRE-1][i]),
            .point (pt_a[i])
        );

        cpl_div_lane #(
            .COORD_WIDTH (COORD_WIDTH),
            .NW          (NW),
            .DENW        (DENW),
            .QB          (QB)
        ) u_lane_b (
            .clk   (clk),
            .en    (en),
            .num   (pb_reg[i]),
            .den   (dmag_reg),
            .base  (b0_reg[PRE-1][i]),
            .point (pt_b[i])
        );
    end

    logic ok_out;
    assign ok_out = (lst_reg[LANE_LAT-1] == ST_OK);

    assign out_ch.valid     = lv_reg[LANE_LAT-1];
    assign out_ch.status    = lst_reg[LANE_LAT-1];
    assign out_ch.point_a_x = ok_out ? pt_a[0] : '0;
    assign out_ch.point_a_y = ok_out ? pt_a[1] : '0;
    assign out_ch.point_a_z = ok_out ? pt_a[2] : '0;
    assign out_ch.point_b_x = ok_out ? pt_b[0] : '0;
    assign out_ch.point_b_y = ok_out ? pt_b[1] : '0;
    assign out_ch.point_b_z = ok_out ? pt_b[2] : '0;

endmodule

@@ src/cpl_checker.sv @@
// Port-level checks for the closest points block, bound to the top level.
`include "closest_points_between_3d_lines_defines.svh"

module cpl_checker import cpl_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [1:0]                    status,
    input logic signed [COORD_WIDTH-1:0] point_a_x,
    input logic signed [COORD_WIDTH-1:0] point_b_z
);

    `CPL_ASSERT_NOW(a_ready_follows, clk, rst_n, out_ready, in_ready, "input stalled while output drains")
    `CPL_ASSERT_NOW(a_degen_zero, clk, rst_n, out_valid && status != ST_OK, point_a_x == '0 && point_b_z == '0, "degenerate item with nonzero point")
    `CPL_ASSERT_NEXT(a_valid_hold, clk, rst_n, out_valid && !out_ready, out_valid, "output item dropped")
    `CPL_ASSERT_NEXT(a_status_hold, clk, rst_n, out_valid && !out_ready, $stable(status), "stalled status changed")

endmodule

bind closest_points_between_3d_lines cpl_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_cpl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (out_ch.status),
    .point_a_x (out_ch.point_a_x),
    .point_b_z (out_ch.point_b_z)
);
